// File: hw/rtl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal averager: item codes, the
// queued word between front and back, and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
package vna_pkg;

   // store sizes
   localparam int MAX_VERTICES = 1024;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = 11;
   localparam int ACCUM_BITS   = 24;
   localparam int POS_W        = 16;
   localparam int N_W          = 16;

   // edge and cross product widths
   localparam int EDGE_W  = POS_W + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;

   // normaliser widths
   localparam int VEC_W  = 36;
   localparam int MAG_W  = VEC_W;
   localparam int NRM_W  = 24;
   localparam int SQ_W   = 50;
   localparam int LEN_W  = 25;
   localparam int FRAC_W = 15;
   localparam int NUM_W  = NRM_W + FRAC_W + 1;
   localparam int DIV_W  = NUM_W + 1;
   localparam int Q_W    = 16;

   // front to back queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_TRI   = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      K_WRITE = 2'd0,
      K_TRI   = 2'd1,
      K_READ  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [IDX_W-1:0]          vertex_index;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic [IDX_W-1:0]          tri_a;
      logic [IDX_W-1:0]          tri_b;
      logic [IDX_W-1:0]          tri_c;
      logic                      index_error;
   } item_type;

endpackage

// File: hw/rtl/vertex_normal_averager.sv
// ----------------------------------------------------------------------------
// vertex_normal_averager
// Smooth vertex normals: per-vertex position store and saturating normal
// accumulators, fed through a front stage and a short queue to the back.
// ----------------------------------------------------------------------------
// After reset the block zeroes the accumulators in a clearing pass, with full
// held high; csr writes are taken at any time. A word passes through the
// front stage register and the queue before the back end takes it. There the
// time that a triangle or an in-range normal read takes is set by the shared
// normaliser: a start step, one normalising shift per cycle until the range
// is reached, then 3 squaring steps, 25 root steps, 16 divide steps and a
// step to form the result. A triangle whose cross product is zero and a read
// of a zero accumulator skip those steps, and an out of range read goes
// straight to the result register. Words queue up in front of the back end
// while it works; a finished result waits in its own register, and a read
// that finds that register still full holds the back end until the waiting
// word is popped.
module vertex_normal_averager import vna_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [1:0]              req_func,
   input  logic [IDX_W-1:0]        req_vertex_index,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [IDX_W-1:0]        req_tri_a,
   input  logic [IDX_W-1:0]        req_tri_b,
   input  logic [IDX_W-1:0]        req_tri_c,
   output logic                    empty,
   input  logic                    pop,
   output logic [IDX_W-1:0]        rsp_out_index,
   output logic signed [N_W-1:0]   rsp_normal_x,
   output logic signed [N_W-1:0]   rsp_normal_y,
   output logic signed [N_W-1:0]   rsp_normal_z,
   output logic                    rsp_index_error,
   input  logic                    valid,
   output logic                    ready,
   input  logic [CNT_W-1:0]        csr_wdata
);

   logic     clearing;
   logic     q_full, q_empty, q_push, q_pop;
   item_type q_in_word, q_out_word;

   vna_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_func         (req_func),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_tri_a        (req_tri_a),
      .req_tri_b        (req_tri_b),
      .req_tri_c        (req_tri_c),
      .valid            (valid),
      .ready            (ready),
      .csr_wdata        (csr_wdata),
      .clearing         (clearing),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_word           (q_in_word)
   );

   vna_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_in_word),
      .q_full    (q_full),
      .pop       (q_pop),
      .q_empty   (q_empty),
      .pop_word  (q_out_word)
   );

   vna_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_word          (q_out_word),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_index   (rsp_out_index),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_normal_z    (rsp_normal_z),
      .rsp_index_error (rsp_index_error)
   );

endmodule

// File: hw/rtl/vna_queue.sv
// ----------------------------------------------------------------------------
// vna_queue
// Short register queue that parts the front from the back.
// ----------------------------------------------------------------------------
module vna_queue import vna_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_word,
   output logic     q_full,
   input  logic     pop,
   output logic     q_empty,
   output item_type pop_word
);

   item_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign q_full   = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign q_empty  = (cnt_ff == '0);
   assign pop_word = mem_ff[rd_ff];
   assign do_push  = push & ~q_full;
   assign do_pop   = pop & ~q_empty;

   // pointer and fill count
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

endmodule

// File: hw/rtl/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front
// Takes request words, holds the vertex count register, checks indices and
// drops words that do nothing before they reach the queue.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [1:0]              req_func,
   input  logic [IDX_W-1:0]        req_vertex_index,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [IDX_W-1:0]        req_tri_a,
   input  logic [IDX_W-1:0]        req_tri_b,
   input  logic [IDX_W-1:0]        req_tri_c,
   input  logic                    valid,
   output logic                    ready,
   input  logic [CNT_W-1:0]        csr_wdata,
   input  logic                    clearing,
   input  logic                    q_full,
   output logic                    q_push,
   output item_type                q_word
);

   logic [CNT_W-1:0] vcount_ff;
   logic             fr_valid_ff, fr_valid_in;
   item_type         fr_item_ff, fr_item_in;
   logic             accept, keep;
   logic             a_ok, b_ok, c_ok, v_ok;

   assign ready  = 1'b1;
   assign full   = clearing | (fr_valid_ff & q_full);
   assign accept = push & ~full;
   assign q_push = fr_valid_ff & ~q_full;
   assign q_word = fr_item_ff;

   // range checks against the vertex count
   assign a_ok = ({1'b0, req_tri_a} < vcount_ff);
   assign b_ok = ({1'b0, req_tri_b} < vcount_ff);
   assign c_ok = ({1'b0, req_tri_c} < vcount_ff);
   assign v_ok = ({1'b0, req_vertex_index} < vcount_ff);

   // classify the word
   always_comb begin
      fr_item_in.kind         = K_WRITE;
      fr_item_in.vertex_index = req_vertex_index;
      fr_item_in.pos_x        = req_pos_x;
      fr_item_in.pos_y        = req_pos_y;
      fr_item_in.pos_z        = req_pos_z;
      fr_item_in.tri_a        = req_tri_a;
      fr_item_in.tri_b        = req_tri_b;
      fr_item_in.tri_c        = req_tri_c;
      fr_item_in.index_error  = ~v_ok;
      keep = 1'b0;
      unique case (req_func)
         FUNC_WRITE: begin
            fr_item_in.kind = K_WRITE;
            keep = 1'b1;
         end
         FUNC_TRI: begin
            fr_item_in.kind = K_TRI;
            keep = a_ok & b_ok & c_ok;
         end
         FUNC_READ: begin
            fr_item_in.kind = K_READ;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // holding stage
   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (q_push) begin
         fr_valid_in = 1'b0;
      end
      if (accept) begin
         fr_valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
         vcount_ff   <= '0;
      end else begin
         fr_valid_ff <= fr_valid_in;
         if (valid) begin
            vcount_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_item_ff <= fr_item_in;
      end
   end

endmodule

// File: hw/rtl/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Iterative unit scaling of a vector to Q1.14: normalising shift one bit a
// cycle, sum of squares, bit-serial square root, three restoring dividers.
// ----------------------------------------------------------------------------
module vna_norm import vna_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VEC_W-1:0] vec_x,
   input  logic signed [VEC_W-1:0] vec_y,
   input  logic signed [VEC_W-1:0] vec_z,
   output logic                    done,
   output logic signed [N_W-1:0]   n_x,
   output logic signed [N_W-1:0]   n_y,
   output logic signed [N_W-1:0]   n_z
);

   typedef enum logic [5:0] {
      N_IDLE  = 6'b000001,
      N_SHIFT = 6'b000010,
      N_SQR   = 6'b000100,
      N_SQRT  = 6'b001000,
      N_DIV   = 6'b010000,
      N_DONE  = 6'b100000
   } nstate_type;

   nstate_type             state_ff, state_in;
   logic [MAG_W-1:0]       mag_ff [3];
   logic [2:0]             sign_ff;
   logic [1:0]             sq_cnt_ff;
   logic [3:0]             div_cnt_ff;
   logic [SQ_W-1:0]        sq_ff;
   logic [SQ_W-1:0]        res_ff;
   logic [SQ_W-1:0]        bit_ff;
   logic [DIV_W-1:0]       rem_ff [3];
   logic [DIV_W-1:0]       dsh_ff;
   logic [Q_W-1:0]         q_ff [3];
   logic signed [N_W-1:0]  n_ff [3];
   logic [MAG_W-1:0]       m_max, m_ab;
   logic [MAG_W-1:0]       abs_in [3];
   logic [NRM_W-1:0]       sq_sel;
   logic [SQ_W-1:0]        sq_prod;
   logic [SQ_W-1:0]        trial;
   logic [LEN_W-1:0]       len;

   assign done = (state_ff == N_DONE);
   assign n_x  = n_ff[0];
   assign n_y  = n_ff[1];
   assign n_z  = n_ff[2];

   // magnitudes of the incoming vector
   assign abs_in[0] = vec_x[VEC_W-1] ? MAG_W'(-vec_x) : MAG_W'(vec_x);
   assign abs_in[1] = vec_y[VEC_W-1] ? MAG_W'(-vec_y) : MAG_W'(vec_y);
   assign abs_in[2] = vec_z[VEC_W-1] ? MAG_W'(-vec_z) : MAG_W'(vec_z);

   // largest magnitude
   assign m_ab  = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign m_max = (m_ab > mag_ff[2]) ? m_ab : mag_ff[2];

   assign sq_sel  = mag_ff[sq_cnt_ff][NRM_W-1:0];
   assign sq_prod = SQ_W'(sq_sel * sq_sel);
   assign trial   = res_ff + bit_ff;
   assign len     = res_ff[LEN_W-1:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               state_in = (abs_in[0] == '0 && abs_in[1] == '0 && abs_in[2] == '0)
                        ? N_DONE : N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (!(|m_max[MAG_W-1:NRM_W]) && m_max[NRM_W-1]) begin
               state_in = N_SQR;
            end
         end
         N_SQR: begin
            if (sq_cnt_ff == 2'd2) begin
               state_in = N_SQRT;
            end
         end
         N_SQRT: begin
            if (bit_ff == SQ_W'(1)) begin
               state_in = N_DIV;
            end
         end
         N_DIV: begin
            if (div_cnt_ff == 4'd15) begin
               state_in = N_DONE;
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         N_IDLE: begin
            sq_cnt_ff  <= '0;
            div_cnt_ff <= '0;
            sq_ff      <= '0;
            res_ff     <= '0;
            bit_ff     <= SQ_W'(1) << (SQ_W - 2);
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= abs_in[i];
            end
            sign_ff <= {vec_z[VEC_W-1], vec_y[VEC_W-1], vec_x[VEC_W-1]};
         end
         N_SHIFT: begin
            for (int i = 0; i < 3; i++) begin
               if (|m_max[MAG_W-1:NRM_W]) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end else if (!m_max[NRM_W-1]) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         N_SQR: begin
            sq_ff     <= sq_ff + sq_prod;
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
            res_ff    <= '0;
         end
         N_SQRT: begin
            if (sq_ff >= trial) begin
               sq_ff  <= sq_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            // divider set-up for the step after the last root step
            for (int i = 0; i < 3; i++) begin
               q_ff[i] <= '0;
            end
         end
         N_DIV: begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (rem_ff[i] >= dsh_ff) begin
                  rem_ff[i] <= rem_ff[i] - dsh_ff;
                  q_ff[i]   <= {q_ff[i][Q_W-2:0], 1'b1};
               end else begin
                  q_ff[i]   <= {q_ff[i][Q_W-2:0], 1'b0};
               end
            end
            dsh_ff <= dsh_ff >> 1;
         end
         N_DONE: begin
            // output held until the next vector is done
            for (int i = 0; i < 3; i++) begin
               n_ff[i] <= sign_ff[i] ? -$signed(q_ff[i]) : $signed(q_ff[i]);
            end
         end
         default: begin
            sq_cnt_ff <= '0;
         end
      endcase
      // load the dividers as the root finishes
      if (state_ff == N_SQRT && state_in == N_DIV) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= DIV_W'({mag_ff[i][NRM_W-1:0], {FRAC_W{1'b0}}})
                       + DIV_W'(state_ff == N_SQRT && sq_ff >= trial
                                ? (res_ff >> 1) + bit_ff : res_ff >> 1);
         end
         dsh_ff <= DIV_W'(sq_ff >= trial ? (res_ff >> 1) + bit_ff : res_ff >> 1)
                   << (FRAC_W + 1);
      end
      // the zero vector skips the divider and keeps zero quotients
      if (state_ff == N_IDLE) begin
         for (int i = 0; i < 3; i++) begin
            q_ff[i] <= '0;
         end
      end
   end

`ifndef SYNTHESIS
   a_mag_normed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == N_SQR) |-> !(|m_max[MAG_W-1:NRM_W]) && m_max[NRM_W-1])
      else $error("normaliser left the shift with the largest component out of range");
   a_len_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == N_DIV && div_cnt_ff == 4'd0) |-> (len >= LEN_W'(1) << (NRM_W - 1)))
      else $error("root below the normalised floor");
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      done |-> (q_ff[0] <= Q_W'(16384)) && (q_ff[1] <= Q_W'(16384))
               && (q_ff[2] <= Q_W'(16384)))
      else $error("unit component above one");
`endif

endmodule

// File: hw/rtl/vna_back.sv
// ----------------------------------------------------------------------------
// vna_back
// Carries out queued words: position and accumulator stores, the cross
// product, accumulator updates and the result register.
// ----------------------------------------------------------------------------
module vna_back import vna_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  item_type                q_word,
   output logic                    q_pop,
   output logic                    clearing,
   output logic                    empty,
   input  logic                    pop,
   output logic [IDX_W-1:0]        rsp_out_index,
   output logic signed [N_W-1:0]   rsp_normal_x,
   output logic signed [N_W-1:0]   rsp_normal_y,
   output logic signed [N_W-1:0]   rsp_normal_z,
   output logic                    rsp_index_error
);

   typedef enum logic [13:0] {
      B_CLEAR  = 14'b00000000000001,
      B_IDLE   = 14'b00000000000010,
      B_WRITE  = 14'b00000000000100,
      B_PA     = 14'b00000000001000,
      B_PB     = 14'b00000000010000,
      B_PC     = 14'b00000000100000,
      B_EDGE   = 14'b00000001000000,
      B_CROSS  = 14'b00000010000000,
      B_RRD    = 14'b00000100000000,
      B_NSTART = 14'b00001000000000,
      B_NWAIT  = 14'b00010000000000,
      B_ARD    = 14'b00100000000000,
      B_AWR    = 14'b01000000000000,
      B_RESULT = 14'b10000000000000
   } bstate_type;

   localparam int PW = 3 * POS_W;
   localparam int AW = 3 * ACCUM_BITS;

   bstate_type                 state_ff, state_in;
   item_type                   item_ff;
   logic [IDX_W-1:0]           clr_ff;
   logic [1:0]                 j_ff;
   logic [1:0]                 x_ff;
   logic [PW-1:0]              pos_mem [MAX_VERTICES];
   logic [AW-1:0]              acc_mem [MAX_VERTICES];
   logic [PW-1:0]              pos_q, pa_ff, pb_ff;
   logic [AW-1:0]              acc_q;
   logic signed [EDGE_W-1:0]   e1_ff [3];
   logic signed [EDGE_W-1:0]   e2_ff [3];
   logic signed [CROSS_W-1:0]  cr_ff [3];
   logic [IDX_W-1:0]           pos_raddr, acc_addr, k_sel;
   logic                       acc_we;
   logic [AW-1:0]              acc_wdata;
   logic signed [EDGE_W-1:0]   m1a, m1b, m2a, m2b;
   logic signed [PROD_W-1:0]   p1, p2;
   logic signed [VEC_W-1:0]    nv [3];
   logic                       n_start, n_done;
   logic signed [N_W-1:0]      n_out [3];
   logic signed [ACCUM_BITS-1:0] acc_c [3];
   logic signed [ACCUM_BITS:0]   acc_sum [3];
   logic [ACCUM_BITS-1:0]        acc_sat [3];
   logic                       res_valid_ff;
   logic                       res_load;

   assign clearing = (state_ff == B_CLEAR);
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign empty    = ~res_valid_ff;
   assign res_load = (state_ff == B_RESULT) && (!res_valid_ff || pop);
   assign n_start  = (state_ff == B_NSTART);

   // corner select for the accumulator updates
   always_comb begin
      case (j_ff)
         2'd0:    k_sel = item_ff.tri_a;
         2'd1:    k_sel = item_ff.tri_b;
         default: k_sel = item_ff.tri_c;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: begin
            if (clr_ff == IDX_W'(MAX_VERTICES - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               unique case (q_word.kind)
                  K_WRITE: state_in = B_WRITE;
                  K_TRI:   state_in = B_PA;
                  K_READ:  state_in = q_word.index_error ? B_RESULT : B_RRD;
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_WRITE:  state_in = B_IDLE;
         B_PA:     state_in = B_PB;
         B_PB:     state_in = B_PC;
         B_PC:     state_in = B_EDGE;
         B_EDGE:   state_in = B_CROSS;
         B_CROSS: begin
            if (x_ff == 2'd2) begin
               state_in = B_NSTART;
            end
         end
         B_RRD:    state_in = B_NSTART;
         B_NSTART: state_in = B_NWAIT;
         B_NWAIT: begin
            if (n_done) begin
               state_in = (item_ff.kind == K_READ) ? B_RESULT : B_ARD;
            end
         end
         B_ARD:    state_in = B_AWR;
         B_AWR: begin
            if (j_ff == 2'd2) begin
               state_in = B_IDLE;
            end else begin
               state_in = B_ARD;
            end
         end
         B_RESULT: begin
            if (res_load) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // position store
   always_comb begin
      case (state_ff)
         B_PA:    pos_raddr = item_ff.tri_a;
         B_PB:    pos_raddr = item_ff.tri_b;
         default: pos_raddr = item_ff.tri_c;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_WRITE) begin
         pos_mem[item_ff.vertex_index] <= {item_ff.pos_z, item_ff.pos_y, item_ff.pos_x};
      end
      pos_q <= pos_mem[pos_raddr];
   end

   // accumulator store, zeroed by the clearing pass and by vertex writes
   always_comb begin
      acc_addr  = k_sel;
      acc_we    = 1'b0;
      acc_wdata = '0;
      case (state_ff)
         B_CLEAR: begin
            acc_addr = clr_ff;
            acc_we   = 1'b1;
         end
         B_WRITE: begin
            acc_addr = item_ff.vertex_index;
            acc_we   = 1'b1;
         end
         B_RRD: begin
            acc_addr = item_ff.vertex_index;
         end
         B_AWR: begin
            acc_we    = 1'b1;
            acc_wdata = {acc_sat[2], acc_sat[1], acc_sat[0]};
         end
         default: begin
            acc_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_addr] <= acc_wdata;
      end
      acc_q <= acc_mem[acc_addr];
   end

   // saturating add of the unit normal
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_c[i]   = $signed(acc_q[i*ACCUM_BITS +: ACCUM_BITS]);
         acc_sum[i] = (ACCUM_BITS+1)'(acc_c[i]) + (ACCUM_BITS+1)'(n_out[i]);
         if (acc_sum[i][ACCUM_BITS] != acc_sum[i][ACCUM_BITS-1]) begin
            acc_sat[i] = acc_sum[i][ACCUM_BITS]
                       ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                       : {1'b0, {(ACCUM_BITS-1){1'b1}}};
         end else begin
            acc_sat[i] = acc_sum[i][ACCUM_BITS-1:0];
         end
      end
   end

   // cross product operands, one component a cycle
   always_comb begin
      case (x_ff)
         2'd0: begin
            m1a = e1_ff[1]; m1b = e2_ff[2]; m2a = e1_ff[2]; m2b = e2_ff[1];
         end
         2'd1: begin
            m1a = e1_ff[2]; m1b = e2_ff[0]; m2a = e1_ff[0]; m2b = e2_ff[2];
         end
         default: begin
            m1a = e1_ff[0]; m1b = e2_ff[1]; m2a = e1_ff[1]; m2b = e2_ff[0];
         end
      endcase
      p1 = m1a * m1b;
      p2 = m2a * m2b;
   end

   // vector into the normaliser
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (item_ff.kind == K_READ) begin
            nv[i] = VEC_W'($signed(acc_q[i*ACCUM_BITS +: ACCUM_BITS]));
         end else begin
            nv[i] = VEC_W'(cr_ff[i]);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_word;
      end
      case (state_ff)
         B_IDLE: begin
            j_ff <= '0;
            x_ff <= '0;
         end
         B_PB: pa_ff <= pos_q;
         B_PC: pb_ff <= pos_q;
         B_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= EDGE_W'($signed(pb_ff[i*POS_W +: POS_W]))
                         - EDGE_W'($signed(pa_ff[i*POS_W +: POS_W]));
               e2_ff[i] <= EDGE_W'($signed(pos_q[i*POS_W +: POS_W]))
                         - EDGE_W'($signed(pa_ff[i*POS_W +: POS_W]));
            end
         end
         B_CROSS: begin
            cr_ff[x_ff] <= CROSS_W'(p1) - CROSS_W'(p2);
            x_ff <= x_ff + 1'b1;
         end
         B_AWR: j_ff <= j_ff + 1'b1;
         default: begin
            x_ff <= x_ff;
         end
      endcase
   end

   vna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (n_start),
      .vec_x (nv[0]),
      .vec_y (nv[1]),
      .vec_z (nv[2]),
      .done  (n_done),
      .n_x   (n_out[0]),
      .n_y   (n_out[1]),
      .n_z   (n_out[2])
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (res_load) begin
         res_valid_ff <= 1'b1;
      end else if (pop) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_out_index   <= item_ff.vertex_index;
         rsp_index_error <= item_ff.index_error;
         rsp_normal_x    <= item_ff.index_error ? '0 : n_out[0];
         rsp_normal_y    <= item_ff.index_error ? '0 : n_out[1];
         rsp_normal_z    <= item_ff.index_error ? '0 : n_out[2];
      end
   end

`ifndef SYNTHESIS
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop && !res_valid_ff)
      else $error("queue drained during the clearing pass");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      res_load && item_ff.index_error |=> rsp_normal_x == '0 && rsp_normal_y == '0
                                          && rsp_normal_z == '0)
      else $error("out of range read returned a non-zero normal");
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && !pop |=> res_valid_ff && $stable(rsp_out_index))
      else $error("waiting result lost");
`endif

endmodule
